// ----- src/mono_glyph_rect_rasterizer_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the glyph and rectangle rasterizer
// Implication and next-cycle checks, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef MONO_GLYPH_RECT_RASTERIZER_UNIT_ASSERT_SVH
`define MONO_GLYPH_RECT_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define MGR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mgr check failed");

// next-cycle implication
`define MGR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mgr check failed");

`endif

// ----- src/mgr_pkg.sv -----
// ---------------------------------------------------------------------------
// mgr_pkg
// Shared constants, command codes, queue word type and the 5x7 font table.
// ---------------------------------------------------------------------------
package mgr_pkg;

	localparam int PANEL_WIDTH_DEF  = 400;
	localparam int PANEL_HEIGHT_DEF = 300;
	localparam int ADDR_W           = 20;   // wide enough for any panel size

	localparam logic [1:0] MODE_FILL  = 2'd0;
	localparam logic [1:0] MODE_GLYPH = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	typedef logic [4:0][7:0] font_t;    // five columns, bit n is row n

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [10:0] pos_x;
		logic signed [10:0] pos_y;
		logic signed [10:0] rect_width;
		logic signed [10:0] rect_height;
		font_t              font;
		logic [5:0]         scale;
		logic               color;
		logic [13:0]        byte_index;
		logic               drawn;
		logic signed [11:0] next_x;
	} cmd_word_t;

	function automatic font_t font_lookup(input logic [7:0] code_in);
		logic [7:0] code;
		font_t f;
		code = code_in;
		f = '0;
		if (code >= 8'h61 && code <= 8'h7A) code = code - 8'h20;
		case (code)
			8'h41: f = {8'h7E,8'h11,8'h11,8'h11,8'h7E};
			8'h42: f = {8'h36,8'h49,8'h49,8'h49,8'h7F};
			8'h43: f = {8'h22,8'h41,8'h41,8'h41,8'h3E};
			8'h44: f = {8'h1C,8'h22,8'h41,8'h41,8'h7F};
			8'h45: f = {8'h41,8'h49,8'h49,8'h49,8'h7F};
			8'h46: f = {8'h01,8'h09,8'h09,8'h09,8'h7F};
			8'h47: f = {8'h7A,8'h49,8'h49,8'h41,8'h3E};
			8'h48: f = {8'h7F,8'h08,8'h08,8'h08,8'h7F};
			8'h49: f = {8'h00,8'h41,8'h7F,8'h41,8'h00};
			8'h4A: f = {8'h01,8'h3F,8'h41,8'h40,8'h20};
			8'h4B: f = {8'h41,8'h22,8'h14,8'h08,8'h7F};
			8'h4C: f = {8'h40,8'h40,8'h40,8'h40,8'h7F};
			8'h4D: f = {8'h7F,8'h02,8'h0C,8'h02,8'h7F};
			8'h4E: f = {8'h7F,8'h10,8'h08,8'h04,8'h7F};
			8'h4F: f = {8'h3E,8'h41,8'h41,8'h41,8'h3E};
			8'h50: f = {8'h06,8'h09,8'h09,8'h09,8'h7F};
			8'h51: f = {8'h5E,8'h21,8'h51,8'h41,8'h3E};
			8'h52: f = {8'h46,8'h29,8'h19,8'h09,8'h7F};
			8'h53: f = {8'h31,8'h49,8'h49,8'h49,8'h46};
			8'h54: f = {8'h01,8'h01,8'h7F,8'h01,8'h01};
			8'h55: f = {8'h3F,8'h40,8'h40,8'h40,8'h3F};
			8'h56: f = {8'h1F,8'h20,8'h40,8'h20,8'h1F};
			8'h57: f = {8'h3F,8'h40,8'h38,8'h40,8'h3F};
			8'h58: f = {8'h63,8'h14,8'h08,8'h14,8'h63};
			8'h59: f = {8'h07,8'h08,8'h70,8'h08,8'h07};
			8'h5A: f = {8'h43,8'h45,8'h49,8'h51,8'h61};
			8'h30: f = {8'h3E,8'h45,8'h49,8'h51,8'h3E};
			8'h31: f = {8'h00,8'h40,8'h7F,8'h42,8'h00};
			8'h32: f = {8'h46,8'h49,8'h51,8'h61,8'h42};
			8'h33: f = {8'h31,8'h4B,8'h45,8'h41,8'h21};
			8'h34: f = {8'h10,8'h7F,8'h12,8'h14,8'h18};
			8'h35: f = {8'h39,8'h45,8'h45,8'h45,8'h27};
			8'h36: f = {8'h30,8'h49,8'h49,8'h4A,8'h3C};
			8'h37: f = {8'h03,8'h05,8'h09,8'h71,8'h01};
			8'h38: f = {8'h36,8'h49,8'h49,8'h49,8'h36};
			8'h39: f = {8'h1E,8'h29,8'h49,8'h49,8'h06};
			8'h2D: f = {8'h08,8'h08,8'h08,8'h08,8'h08};
			8'h2E: f = {8'h00,8'h00,8'h60,8'h60,8'h00};
			8'h3A: f = {8'h00,8'h00,8'h36,8'h36,8'h00};
			8'h2F: f = {8'h02,8'h04,8'h08,8'h10,8'h20};
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

// ----- src/mgr_if.sv -----
// ---------------------------------------------------------------------------
// mgr_cmd_if / mgr_res_if
// Valid/ready channels for command words and result words.
// ---------------------------------------------------------------------------
interface mgr_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [10:0] pos_x;
	logic signed [10:0] pos_y;
	logic signed [10:0] rect_width;
	logic signed [10:0] rect_height;
	logic [7:0]         char_code;
	logic [5:0]         scale;
	logic               color;
	logic [13:0]        byte_index;
	modport source (output valid, mode, pos_x, pos_y, rect_width, rect_height,
		char_code, scale, color, byte_index, input ready);
	modport sink (input valid, mode, pos_x, pos_y, rect_width, rect_height,
		char_code, scale, color, byte_index, output ready);
endinterface

interface mgr_res_if;
	logic               valid;
	logic               ready;
	logic [7:0]         read_data;
	logic               drawn;
	logic signed [11:0] next_x;
	modport source (output valid, read_data, drawn, next_x, input ready);
	modport sink (input valid, read_data, drawn, next_x, output ready);
endinterface

// ----- src/mgr_front.sv -----
// ---------------------------------------------------------------------------
// mgr_front
// Accepts command words, looks up the glyph shape and settles drawn/next_x.
// ---------------------------------------------------------------------------
module mgr_front #(
	parameter int PANEL_WIDTH = mgr_pkg::PANEL_WIDTH_DEF
) (
	mgr_cmd_if.sink              cmd,
	input  logic                 q_full,
	output logic                 q_push,
	output mgr_pkg::cmd_word_t   q_word
);

	logic signed [12:0] fit_x;
	logic signed [11:0] adv_x;
	logic               glyph_ok;

	// check the glyph against the right edge and work out the pen advance
	always_comb begin
		fit_x    = 13'(cmd.pos_x) + $signed({4'b0, 9'(cmd.scale * 4'd5)});
		adv_x    = 12'(cmd.pos_x) + $signed({3'b0, 9'(cmd.scale * 4'd6)});
		glyph_ok = (cmd.scale != '0) && (cmd.char_code != '0) &&
			(fit_x <= 13'(PANEL_WIDTH));
	end

	// build the queue word
	always_comb begin
		q_word             = '0;
		q_word.mode        = cmd.mode;
		q_word.pos_x       = cmd.pos_x;
		q_word.pos_y       = cmd.pos_y;
		q_word.rect_width  = cmd.rect_width;
		q_word.rect_height = cmd.rect_height;
		q_word.font        = mgr_pkg::font_lookup(cmd.char_code);
		q_word.scale       = cmd.scale;
		q_word.color       = cmd.color;
		q_word.byte_index  = cmd.byte_index;
		if (cmd.mode == mgr_pkg::MODE_GLYPH) begin
			q_word.drawn  = glyph_ok;
			q_word.next_x = glyph_ok ? adv_x : 12'(cmd.pos_x);
		end
	end

	assign cmd.ready = !q_full;
	assign q_push    = cmd.valid && !q_full;

endmodule

// ----- src/mgr_queue.sv -----
// ---------------------------------------------------------------------------
// mgr_queue
// Two-entry queue of command words between front and back.
// ---------------------------------------------------------------------------
module mgr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mgr_pkg::cmd_word_t push_word,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output mgr_pkg::cmd_word_t head
);

	mgr_pkg::cmd_word_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	// hold entries
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_word;
	end

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

endmodule

// ----- src/mgr_back.sv -----
// ---------------------------------------------------------------------------
// mgr_back
// Clears the framebuffer, then runs commands: pixel read-modify-write over
// clipped rectangles and glyph cells, byte reads, and result delivery.
// ---------------------------------------------------------------------------
`include "mono_glyph_rect_rasterizer_unit_assert.svh"

module mgr_back #(
	parameter int PANEL_WIDTH  = mgr_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = mgr_pkg::PANEL_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  mgr_pkg::cmd_word_t q_head,
	output logic               q_pop,
	mgr_res_if.source          res
);

	localparam int FB_BYTES = ((PANEL_WIDTH + 1) / 2) * ((PANEL_HEIGHT + 3) / 4);
	localparam int FB_AW    = $clog2(FB_BYTES);
	localparam int AW       = mgr_pkg::ADDR_W;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_CELL  = 9'b000000100,
		S_NEXT  = 9'b000001000,
		S_SETUP = 9'b000010000,
		S_PIXRD = 9'b000100000,
		S_PIXWR = 9'b001000000,
		S_RDW   = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [FB_AW-1:0]   clr_q;
	logic               out_valid_q;
	mgr_pkg::cmd_word_t cmd_q;
	logic signed [12:0] rx_q, ry_q, rw_q, rh_q;
	logic [10:0]        x0_q, x1_q, y1_q, cx_q, cy_q;
	logic [2:0]         col_q, row_q;
	logic               glyph_q;
	logic [FB_AW-1:0]   addr_q;
	logic               addr_ok_q;
	logic [7:0]         mask_q;
	logic [7:0]         rd_q;
	logic [7:0]         out_rd_q;
	logic               out_drawn_q;
	logic signed [11:0] out_nx_q;
	logic               fill_hit_q;

	logic [7:0]         mem_q [FB_BYTES];
	logic [7:0]         mem_rdata_q;
	logic               mem_we, mem_re;
	logic [FB_AW-1:0]   mem_waddr, mem_raddr;
	logic [7:0]         mem_wdata;

	logic signed [13:0] xe, ye, sx0, sx1, sy0, sy1;
	logic               rect_empty;
	logic [10:0]        iy;
	logic [AW-1:0]      pix_addr;
	logic [2:0]         bitn;
	logic               pix_last_col, pix_last;
	logic [AW-1:0]      rd_idx;
	logic               rd_in_range;
	logic               cell_set, cell_last;
	logic               load_out;

	// clip the current rectangle to the panel
	always_comb begin
		xe  = 14'(rx_q) + 14'(rw_q);
		ye  = 14'(ry_q) + 14'(rh_q);
		sx0 = (rx_q < 0) ? 14'sd0 : 14'(rx_q);
		sy0 = (ry_q < 0) ? 14'sd0 : 14'(ry_q);
		sx1 = (xe > 14'(PANEL_WIDTH))  ? 14'(PANEL_WIDTH)  : xe;
		sy1 = (ye > 14'(PANEL_HEIGHT)) ? 14'(PANEL_HEIGHT) : ye;
		rect_empty = (sx1 <= sx0) || (sy1 <= sy0);
	end

	// map the pixel under the cursor to byte address and bit
	always_comb begin
		iy       = 11'(PANEL_HEIGHT - 1) - cy_q;
		pix_addr = AW'(cx_q[10:1]) * AW'(PANEL_HEIGHT >> 2) + AW'(iy[10:2]);
		bitn     = 3'd7 - {iy[1:0], cx_q[0]};
		pix_last_col = (cx_q + 11'd1 == x1_q);
		pix_last     = pix_last_col && (cy_q + 11'd1 == y1_q);
		rd_idx       = AW'(q_head.byte_index);
		rd_in_range  = (rd_idx < AW'(FB_BYTES));
		cell_set     = cmd_q.font[col_q][row_q];
		cell_last    = (col_q == 3'd4) && (row_q == 3'd6);
		load_out     = (state_q == S_EMIT) && (!out_valid_q || res.ready);
		q_pop        = (state_q == S_IDLE) && q_valid;
	end

	// drive the memory ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = pix_addr[FB_AW-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				mem_re    = q_pop && (q_head.mode == mgr_pkg::MODE_READ) && rd_in_range;
				mem_raddr = rd_idx[FB_AW-1:0];
			end
			S_PIXRD: begin
				mem_re = 1'b1;
			end
			S_PIXWR: begin
				mem_we    = addr_ok_q;
				mem_waddr = addr_q;
				mem_wdata = cmd_q.color ? (mem_rdata_q | mask_q) : (mem_rdata_q & ~mask_q);
			end
			default: begin
			end
		endcase
	end

	// framebuffer store
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (mem_re) mem_rdata_q <= mem_q[mem_raddr];
	end

	// sequence the commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == FB_AW'(FB_BYTES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_pop) begin
						case (q_head.mode)
							mgr_pkg::MODE_FILL:  state_q <= S_SETUP;
							mgr_pkg::MODE_GLYPH: state_q <= q_head.drawn ? S_CELL : S_EMIT;
							mgr_pkg::MODE_READ:  state_q <= rd_in_range ? S_RDW : S_EMIT;
							default:             state_q <= S_EMIT;
						endcase
					end
				end
				S_CELL:  state_q <= cell_set ? S_SETUP : S_NEXT;
				S_NEXT:  state_q <= cell_last ? S_EMIT : S_CELL;
				S_SETUP: begin
					if (rect_empty) state_q <= glyph_q ? S_NEXT : S_EMIT;
					else state_q <= S_PIXRD;
				end
				S_PIXRD: state_q <= S_PIXWR;
				S_PIXWR: begin
					if (pix_last) state_q <= glyph_q ? S_NEXT : S_EMIT;
					else state_q <= S_PIXRD;
				end
				S_RDW:   state_q <= S_EMIT;
				S_EMIT:  if (load_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_pop) begin
					cmd_q   <= q_head;
					rx_q    <= 13'(q_head.pos_x);
					ry_q    <= 13'(q_head.pos_y);
					rw_q    <= 13'(q_head.rect_width);
					rh_q    <= 13'(q_head.rect_height);
					glyph_q <= (q_head.mode == mgr_pkg::MODE_GLYPH);
					col_q   <= '0;
					row_q   <= '0;
					rd_q    <= '0;
				end
			end
			S_CELL: begin
				rx_q <= 13'(cmd_q.pos_x) + $signed({4'b0, 9'(col_q * cmd_q.scale)});
				ry_q <= 13'(cmd_q.pos_y) + $signed({4'b0, 9'(row_q * cmd_q.scale)});
				rw_q <= $signed({7'b0, cmd_q.scale});
				rh_q <= $signed({7'b0, cmd_q.scale});
			end
			S_NEXT: begin
				if (row_q == 3'd6) begin
					row_q <= '0;
					col_q <= col_q + 3'd1;
				end else begin
					row_q <= row_q + 3'd1;
				end
			end
			S_SETUP: begin
				x0_q <= sx0[10:0];
				x1_q <= sx1[10:0];
				y1_q <= sy1[10:0];
				cx_q <= sx0[10:0];
				cy_q <= sy0[10:0];
			end
			S_PIXRD: begin
				addr_q    <= pix_addr[FB_AW-1:0];
				addr_ok_q <= (pix_addr < AW'(FB_BYTES));
				mask_q    <= 8'b1 << bitn;
			end
			S_PIXWR: begin
				if (pix_last_col) begin
					cx_q <= x0_q;
					cy_q <= cy_q + 11'd1;
				end else begin
					cx_q <= cx_q + 11'd1;
				end
			end
			S_RDW: begin
				rd_q <= mem_rdata_q;
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_rd_q    <= rd_q;
			out_drawn_q <= (cmd_q.mode == mgr_pkg::MODE_FILL) ? fill_hit_q : cmd_q.drawn;
			out_nx_q    <= cmd_q.next_x;
		end
	end

	// remember whether the fill rectangle touched the panel
	always_ff @(posedge clk) begin
		if (q_pop) fill_hit_q <= 1'b0;
		else if (state_q == S_SETUP && !rect_empty && !glyph_q) fill_hit_q <= 1'b1;
	end

	assign res.valid     = out_valid_q;
	assign res.read_data = out_rd_q;
	assign res.drawn     = out_drawn_q;
	assign res.next_x    = out_nx_q;

	`MGR_ASSERT_NXT(a_rd_then_wr, state_q == S_PIXRD, state_q == S_PIXWR)
	`MGR_ASSERT_IMP(a_pop_idle, q_pop, state_q == S_IDLE)
	`MGR_ASSERT_IMP(a_no_out_in_clear, state_q == S_CLEAR, !load_out && !mem_re)
	`MGR_ASSERT_IMP(a_wr_after_rd, mem_we && state_q == S_PIXWR,
		$past(state_q) == S_PIXRD)

endmodule

// ----- src/mono_glyph_rect_rasterizer_unit.sv -----
// ---------------------------------------------------------------------------
// mono_glyph_rect_rasterizer_unit
// 1-bit framebuffer rasterizer: rectangle fill, scaled 5x7 glyphs, byte read.
// ---------------------------------------------------------------------------
// After reset the block sweeps the framebuffer to zero, one byte a cycle
// (FB_BYTES = ceil(W/2)*ceil(H/4) bytes, 15000 at 400x300), and takes no
// command from its queue until that ends; up to two commands wait in the
// queue meanwhile. Every pixel is a read-modify-write on the framebuffer
// store (S_PIXRD, then S_PIXWR); a fill runs S_SETUP and one such pair per
// clipped pixel, a glyph walks the 35 cells (S_CELL, S_NEXT) and fills each
// lit cell likewise, a byte read passes S_RDW. Results come back in command
// order through an output register; a stalled result holds the back end.
module mono_glyph_rect_rasterizer_unit #(
	parameter int PANEL_WIDTH  = mgr_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = mgr_pkg::PANEL_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mgr_cmd_if.sink    cmd,
	mgr_res_if.source  res
);

	logic               q_full, q_push, q_pop, q_valid;
	mgr_pkg::cmd_word_t q_word, q_head;

	mgr_front #(.PANEL_WIDTH(PANEL_WIDTH)) u_front (
		.cmd    (cmd),
		.q_full (q_full),
		.q_push (q_push),
		.q_word (q_word)
	);

	mgr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_word),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	mgr_back #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule
